// ===== hw/rtl/decimal_list_validator_top_defines.svh =====
// Assertion macros for the decimal list validator.
// Used by decimal_list_validator_top; no other dependencies.
`ifndef DECIMAL_LIST_VALIDATOR_TOP_DEFINES_SVH
`define DECIMAL_LIST_VALIDATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DLV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dlv: implication check failed");
`define DLV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dlv: next-cycle check failed");
`else
`define DLV_ASSERT_IMP(lbl, ante, cons)
`define DLV_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/dlv_pkg.sv =====
// Shared types, codes and character helpers for the decimal list validator.
// No dependencies.
`default_nettype none
package dlv_pkg;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOTNUM = 3'd1,
        ST_RANGE  = 3'd2,
        ST_DUP    = 3'd3,
        ST_FULL   = 3'd4,
        ST_SKIP   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_BAD    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_CHECK  = 2'd1,
        S_SCAN   = 2'd2,
        S_FINISH = 2'd3
    } t_state;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       token_end;
        logic       list_end;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [8:0]         position;
        t_status            status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic take_char;   // parse this character
        logic take_token;  // token closes: capture list_end
        logic check;       // latch signed value, reset scan
        logic scan_run;    // walk stored values
        logic commit;      // load result, update list state
    } t_ctrl_cmd;

    typedef struct packed {
        logic early;       // token fails without a scan
        logic scan_done;
    } t_dp_stat;

    localparam logic [7:0]  CH_SPACE = 8'd32;
    localparam logic [7:0]  CH_TAB   = 8'd9;
    localparam logic [7:0]  CH_CR    = 8'd13;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_PLUS  = 8'h2B;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [31:0] MAG_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] MAG_NEG_MAX = 32'h8000_0000;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dlv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dlv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dlv_ctrl.sv =====
// Sequencer for the validator: input/output handshakes and token finish steps.
// Depends on dlv_pkg.
`default_nettype none
module dlv_ctrl
    import dlv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_has_char,
    input  wire logic     i_token_end,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_ctrl_cmd     o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_token_end) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.early ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.take_char  = in_acc && i_has_char;
        o_cmd.take_token = in_acc && i_token_end;
        o_cmd.check      = (r_state == S_CHECK);
        o_cmd.scan_run   = (r_state == S_SCAN);
        o_cmd.commit     = (r_state == S_FINISH) && out_free;
        n_out_valid      = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/dlv_datapath.sv =====
// Datapath: character parser, value store scan, list state and result register.
// Depends on dlv_pkg and dlv_ram.
`default_nettype none
module dlv_datapath
    import dlv_pkg::*;
#(
    parameter int MAX_COUNT = 512
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_ctrl_cmd i_cmd,
    output t_dp_stat       o_stat,
    output t_out_item      o_item
);

    localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_COUNT);

    t_phase        r_phase, n_phase;
    logic          r_neg, n_neg;
    logic          r_seen, n_seen;
    logic [31:0]   r_mag, n_mag;
    logic [CW-1:0] r_count;
    logic          r_failed;
    logic [8:0]    r_pos;
    logic          r_last;
    logic [31:0]   r_val;
    logic [CW-1:0] r_idx;
    logic          r_cmp_v;
    logic          r_hit;
    t_out_item     r_out;

    logic [7:0]    ch;
    logic [3:0]    dig;
    logic [35:0]   prod;
    logic [31:0]   mag_sat;
    logic          bad;
    logic          range_err;
    logic          issue;
    t_status       status;
    logic [31:0]   rdata;

    assign ch      = i_item.ch;
    assign dig     = 4'(ch - CH_ZERO);
    assign prod    = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + 36'(dig);
    assign mag_sat = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];

    // parser step
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_seen  = r_seen;
        n_mag   = r_mag;
        if (i_cmd.take_char) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (is_space(ch)) begin
                        n_phase = PH_LEAD;
                    end else if ((ch == CH_MINUS) || (ch == CH_PLUS)) begin
                        n_neg   = (ch == CH_MINUS);
                        n_phase = PH_SIGN;
                    end else if (is_digit(ch)) begin
                        n_mag   = mag_sat;
                        n_seen  = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (is_digit(ch)) begin
                        n_mag   = mag_sat;
                        n_seen  = 1'b1;
                        n_phase = PH_DIGITS;
                    end else if ((r_phase == PH_DIGITS) && is_space(ch)) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                PH_TRAIL: begin
                    if (!is_space(ch)) begin
                        n_phase = PH_BAD;
                    end
                end
                default: n_phase = PH_BAD;
            endcase
        end
        if (i_cmd.commit) begin
            n_phase = PH_LEAD;
            n_neg   = 1'b0;
            n_seen  = 1'b0;
            n_mag   = '0;
        end
    end

    assign bad       = (r_phase == PH_BAD) || !r_seen;
    assign range_err = r_neg ? (r_mag > MAG_NEG_MAX) : (r_mag > MAG_POS_MAX);

    // one read issued per cycle; compare lags by the RAM read latency
    assign issue = i_cmd.scan_run && (r_idx < r_count) && !r_hit;

    always_comb begin
        priority if (r_failed) begin
            status = ST_SKIP;
        end else if (bad) begin
            status = ST_NOTNUM;
        end else if (range_err) begin
            status = ST_RANGE;
        end else if (r_hit) begin
            status = ST_DUP;
        end else if (r_count == CNT_FULL) begin
            status = ST_FULL;
        end else begin
            status = ST_OK;
        end
    end

    assign o_stat.early     = r_failed || bad || range_err;
    assign o_stat.scan_done = i_cmd.scan_run && !issue && !r_cmp_v;

    dlv_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && (status == ST_OK)),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_val),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_neg    <= 1'b0;
            r_seen   <= 1'b0;
            r_mag    <= '0;
            r_count  <= '0;
            r_failed <= 1'b0;
            r_pos    <= '0;
            r_cmp_v  <= 1'b0;
            r_hit    <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_mag   <= n_mag;
            if (i_cmd.check) begin
                r_idx   <= '0;
                r_cmp_v <= 1'b0;
                r_hit   <= 1'b0;
            end else begin
                r_cmp_v <= issue;
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_cmp_v && (rdata == r_val)) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_count  <= '0;
                    r_failed <= 1'b0;
                    r_pos    <= '0;
                end else begin
                    r_pos <= r_pos + 9'd1;
                    if (status == ST_OK) begin
                        r_count <= r_count + CW'(1);
                    end
                    if ((status != ST_OK) && (status != ST_SKIP)) begin
                        r_failed <= 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_token) begin
            r_last <= i_item.list_end;
        end
        if (i_cmd.check) begin
            r_val <= r_neg ? (~r_mag + 32'd1) : r_mag;
        end
        if (i_cmd.commit) begin
            r_out.value    <= (status == ST_OK) ? r_val : 32'd0;
            r_out.position <= r_pos;
            r_out.status   <= status;
            r_out.last     <= r_last;
        end
    end

    assign o_item = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/decimal_list_validator_top.sv =====
// Top level of the decimal list validator: controller, datapath and checks.
// Depends on dlv_pkg, dlv_ctrl, dlv_datapath and the defines header.
`default_nettype none
`include "decimal_list_validator_top_defines.svh"
// Decimal list validator. Each input item carries one character of a token
// (or a bare terminator with has_char low) plus token_end and list_end marks.
// A token is optional whitespace (space, codes 9..13), an optional sign, one
// or more digits, then optional whitespace. Each token_end item yields one
// result item: the signed 32-bit value (zero unless status is ok), the token's
// position in the list (low 9 bits), a status code and a last flag that
// closes the list. Status is checked in this order: not a number, out of
// range, duplicate of an earlier value in the list, list full. After the first
// error every further token of the list reports skipped; list_end clears the
// stored values and the error state. Long digit strings saturate the magnitude,
// so they report out of range rather than wrapping.
// Sequence: a character item without token_end is taken in the idle state. A
// token_end item passes through check and finish when the token fails without
// a lookup, and through check, scan and finish otherwise; the scan covers the
// values already stored in the list (a match ends the lookup sooner), and the
// duplicate lookup reads the value store (MAX_COUNT x 32 RAM) one entry per
// cycle through its single read port and drains one read latency at its end.
// A finished result sits in the output register, and characters of the next
// token are taken meanwhile; the next token_end is accepted, but its result and
// the input wait until that earlier result has been taken. The value store
// needs no clearing after reset: only entries written in the current list are
// ever read.
module decimal_list_validator_top
    import dlv_pkg::*;
#(
    parameter int MAX_COUNT = 512
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    t_ctrl_cmd cmd;   // controller -> datapath
    t_dp_stat  stat;  // datapath -> controller

    dlv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_has_char  (i_in_item.has_char),
        .i_token_end (i_in_item.token_end),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dlv_datapath #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_item  (o_out_item)
    );

    // only an ok result carries a value
    `DLV_ASSERT_IMP(a_value_zero_unless_ok,
        o_out_valid && (o_out_item.status != ST_OK), o_out_item.value == 32'sd0)
    // a token end stalls the input while the token is finished
    `DLV_ASSERT_NXT(a_token_end_stalls,
        i_in_valid && o_in_ready && i_in_item.token_end, !o_in_ready)
    // a fresh result only follows a finish step
    `DLV_ASSERT_IMP(a_result_after_finish, $rose(o_out_valid), !$past(o_in_ready))
    // scanning and committing never overlap
    `DLV_ASSERT_IMP(a_scan_commit_apart, cmd.scan_run, !cmd.commit && !cmd.check)

endmodule
`default_nettype wire

// ===== tb/tb_decimal_list_validator_top.sv =====
// Testbench for decimal_list_validator_top: a directed token table, random lists and one full list.
// Depends on dlv_pkg and the decimal_list_validator_top RTL; every token report is checked
// against a behavioral parser kept in this file; typed directed rows use table value and status.
module tb_decimal_list_validator_top;
    import dlv_pkg::*;

    localparam int CAPACITY     = 512;          // value store depth, passed to the block
    localparam int RAND_ITEMS   = 550;          // random input items to feed
    localparam int DRAIN_CYCLES = CAPACITY + 64; // a full-list lookup plus margin

    // ------------------------------------------------------------------
    // Clock, reset and the two channels
    // ------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    always #10 clk = ~clk;

    decimal_list_validator_top #(
        .MAX_COUNT(CAPACITY)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // ------------------------------------------------------------------
    // Parser state mirrored from the block: per-token phase, sign, digit
    // flag and saturating magnitude, plus the per-list value store.
    // ------------------------------------------------------------------
    t_phase      ph      = PH_LEAD;
    logic        neg     = 1'b0;
    logic        seen    = 1'b0;
    logic [31:0] mag     = '0;
    logic        failed  = 1'b0;
    logic [31:0] stored [CAPACITY];
    int unsigned nstored = 0;
    int unsigned tok_idx = 0;

    // Reports owed by the block, oldest first.
    t_out_item   token_reports[$];

    // Directed rows: one item each; typed rows carry value and status read
    // straight off the grammar, the rest take the parser's answer.
    typedef struct packed {
        t_in_item    item;
        bit          typed;
        logic [31:0] value;
        t_status     status;
    } t_dir_row;
    t_dir_row    dir_rows[$];

    logic [7:0]  tok_chars[$];  // body of the token being built
    bit          tx_steady = 1'b0;  // sender runs without gaps
    bit          rx_steady = 1'b0;  // receiver never stalls
    int          errors    = 0;
    int          fed       = 0;  // random items, idle fillers not counted
    int          taken     = 0;  // every accepted input item
    int          lists     = 0;
    int          n_reports = 0;
    int          by_status[8];

    // ------------------------------------------------------------------
    // Character classes and the saturating digit shift
    // ------------------------------------------------------------------
    function automatic bit blank_ch(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic bit dec_ch(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // mag * 10 + digit, pinned at all ones so long strings read as out of range
    function automatic logic [31:0] shift_in_digit(input logic [31:0] acc, input logic [7:0] c);
        logic [63:0] wide;
        wide = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
        return (wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? CH_SPACE : r[7:0];
    endfunction

    // ------------------------------------------------------------------
    // Parser: one accepted item in, at most one token report out
    // ------------------------------------------------------------------
    task automatic parse_step(input t_in_item it, output bit produced, output t_out_item rep);
        logic [31:0] v;
        bit          hit;
        t_status     st;
        produced = 1'b0;
        rep      = '0;
        if (it.has_char) begin
            case (ph)
                PH_LEAD: begin
                    if (blank_ch(it.ch)) begin
                        // still in leading whitespace
                    end else if (it.ch == CH_MINUS || it.ch == CH_PLUS) begin
                        neg = (it.ch == CH_MINUS);
                        ph  = PH_SIGN;
                    end else if (dec_ch(it.ch)) begin
                        mag  = shift_in_digit(mag, it.ch);
                        seen = 1'b1;
                        ph   = PH_DIGITS;
                    end else begin
                        ph = PH_BAD;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (dec_ch(it.ch)) begin
                        mag  = shift_in_digit(mag, it.ch);
                        seen = 1'b1;
                        ph   = PH_DIGITS;
                    end else if (ph == PH_DIGITS && blank_ch(it.ch)) begin
                        ph = PH_TRAIL;
                    end else begin
                        ph = PH_BAD;  // includes a blank right after the sign
                    end
                end
                PH_TRAIL: begin
                    if (!blank_ch(it.ch)) ph = PH_BAD;
                end
                default: ph = PH_BAD;
            endcase
        end
        if (!it.token_end) return;  // list_end alone is ignored

        // status priority: skipped, not a number, range, duplicate, full
        v = neg ? (32'd0 - mag) : mag;
        if (failed) begin
            st = ST_SKIP;
        end else if (ph == PH_BAD || !seen) begin
            st = ST_NOTNUM;
        end else if (neg ? (mag > MAG_NEG_MAX) : (mag > MAG_POS_MAX)) begin
            st = ST_RANGE;
        end else begin
            hit = 1'b0;
            for (int i = 0; i < nstored; i++) begin
                if (stored[i] == v) hit = 1'b1;
            end
            if (hit) begin
                st = ST_DUP;
            end else if (nstored >= CAPACITY) begin
                st = ST_FULL;
            end else begin
                stored[nstored] = v;
                nstored++;
                st = ST_OK;
            end
        end
        if (st != ST_OK && st != ST_SKIP) failed = 1'b1;

        produced     = 1'b1;
        rep.value    = (st == ST_OK) ? v : 32'd0;
        rep.position = tok_idx[8:0];
        rep.status   = st;
        rep.last     = it.list_end;

        ph   = PH_LEAD;
        neg  = 1'b0;
        seen = 1'b0;
        mag  = '0;
        tok_idx++;
        if (it.list_end) begin
            nstored = 0;
            failed  = 1'b0;
            tok_idx = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: called at a falling edge, returns at the falling edge after
    // the item is taken. Valid drops only when a gap follows, so a
    // back-to-back item never sees valid lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic push_char(input t_in_item it, input bit typed,
                             input logic [31:0] tv, input t_status ts);
        int        gap;
        bit        produced;
        t_out_item rep;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        taken++;
        parse_step(it, produced, rep);
        if (produced) begin
            if (typed) begin
                rep.value  = tv;
                rep.status = ts;
            end
            token_reports.push_back(rep);
        end
        @(negedge clk);
    endtask

    // Feed tok_chars as one token; closed on its last character or by a
    // bare terminator. Idle fillers (no character, no token end) and stray
    // list_end marks are sprinkled in between.
    task automatic send_token(input bit bare_end, input bit close_list);
        t_in_item it;
        int       n;
        n = tok_chars.size();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                it.ch        = 8'($urandom_range(0, 255));
                it.has_char  = 1'b0;
                it.token_end = 1'b0;
                it.list_end  = ($urandom_range(0, 1) != 0);
                push_char(it, 1'b0, '0, ST_OK);
            end
            it.ch        = tok_chars[k];
            it.has_char  = 1'b1;
            it.token_end = !bare_end && (k == n - 1);
            it.list_end  = it.token_end ? close_list : ($urandom_range(0, 7) == 0);
            push_char(it, 1'b0, '0, ST_OK);
            fed++;
        end
        if (bare_end || n == 0) begin
            it.ch        = 8'($urandom_range(0, 255));
            it.has_char  = 1'b0;
            it.token_end = 1'b1;
            it.list_end  = close_list;
            push_char(it, 1'b0, '0, ST_OK);
            fed++;
        end
    endtask

    // Append the decimal digits of m to tok_chars, most significant first.
    task automatic put_digits(input logic [63:0] m);
        int         at;
        logic [7:0] d;
        at = tok_chars.size();
        do begin
            d = 8'(m % 64'd10);
            tok_chars.insert(at, CH_ZERO + d);
            m = m / 64'd10;
        end while (m != 0);
    endtask

    task automatic add_row(input logic [7:0] c, input int hc, input int te, input int le,
                           input int typed, input logic [31:0] v, input t_status s);
        t_dir_row r;
        r.item.ch        = c;
        r.item.has_char  = (hc != 0);
        r.item.token_end = (te != 0);
        r.item.list_end  = (le != 0);
        r.typed          = (typed != 0);
        r.value          = v;
        r.status         = s;
        dir_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Receiver: draws a stall per report, then holds ready until a report
    // is taken and checks it against the oldest owed report.
    // ------------------------------------------------------------------
    initial begin : report_sink
        int        gap;
        t_out_item got;
        t_out_item want;
        out_ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got = out_item;
            n_reports++;
            by_status[got.status]++;
            if (token_reports.size() == 0) begin
                $error("report with none owed: value %0d position %0d status %0d last %0d",
                       got.value, got.position, got.status, got.last);
                errors++;
            end else begin
                want = token_reports.pop_front();
                if (got.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, got.value);
                    errors++;
                end
                if (got.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, got.position);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          kind;
        int          ntok;
        int          pick;
        bit          bare;
        logic [63:0] m;

        in_valid = 1'b0;
        in_item  = '0;
        rst_n    = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. First list: plain digit, minus zero, blanks and
        // plus sign, an idle filler, list_end without token_end, a bare
        // terminator, then a duplicate that fails the list and two skips.
        add_row(CH_ZERO + 8'd7, 1, 1, 0, 1, 32'd7, ST_OK);
        add_row(CH_MINUS,       1, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_ZERO,        1, 1, 0, 1, 32'd0, ST_OK);
        add_row(CH_SPACE,       1, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_PLUS,        1, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd5, 1, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_CR,          1, 1, 0, 1, 32'd5, ST_OK);
        add_row(8'hA5,          0, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd3, 1, 0, 1, 0, 32'd0, ST_OK);
        add_row(8'h00,          0, 1, 0, 1, 32'd3, ST_OK);
        add_row(CH_ZERO + 8'd7, 1, 1, 0, 1, 32'd0, ST_DUP);
        add_row(CH_ZERO + 8'd1, 1, 1, 0, 1, 32'd0, ST_SKIP);
        add_row(8'hFF,          0, 1, 1, 1, 32'd0, ST_SKIP);
        // sign with no digits
        add_row(CH_MINUS,       1, 1, 0, 1, 32'd0, ST_NOTNUM);
        add_row(CH_ZERO + 8'd9, 1, 1, 1, 1, 32'd0, ST_SKIP);
        // blank right after the sign
        add_row(CH_PLUS,        1, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_SPACE,       1, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd4, 1, 1, 1, 1, 32'd0, ST_NOTNUM);
        // character codes 0 and 255
        add_row(8'h00,          1, 1, 1, 1, 32'd0, ST_NOTNUM);
        add_row(8'hFF,          1, 1, 0, 1, 32'd0, ST_NOTNUM);
        add_row(8'h00,          0, 1, 1, 1, 32'd0, ST_SKIP);
        // digit after trailing whitespace
        add_row(CH_ZERO + 8'd8, 1, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_TAB,         1, 0, 0, 0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd1, 1, 1, 1, 1, 32'd0, ST_NOTNUM);
        // empty token
        add_row(8'h00,          0, 1, 1, 1, 32'd0, ST_NOTNUM);
        foreach (dir_rows[i])
            push_char(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].value, dir_rows[i].status);
        lists = 7;

        // Random lists. Half the tokens are well formed; the rest are
        // corrupted numbers, random bytes, lone or spaced signs, and empty
        // tokens. Small values make duplicates common; edge magnitudes and
        // long digit runs hit the range check and saturation.
        fed = 0;
        while (fed < RAND_ITEMS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            ntok      = $urandom_range(1, 8);
            for (int t = 0; t < ntok; t++) begin
                tok_chars.delete();
                kind = $urandom_range(0, 99);
                bare = ($urandom_range(0, 3) == 0);
                if (kind < 65) begin
                    repeat ($urandom_range(0, 2)) tok_chars.push_back(pick_blank());
                    pick = $urandom_range(0, 2);
                    if (pick == 1) tok_chars.push_back(CH_PLUS);
                    if (pick == 2) tok_chars.push_back(CH_MINUS);
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        put_digits(64'($urandom_range(0, 15)));
                    end else if (pick < 65) begin
                        put_digits({32'd0, $urandom()});
                    end else if (pick < 85) begin
                        case ($urandom_range(0, 5))
                            0:       m = 64'd2147483647;
                            1:       m = 64'd2147483648;
                            2:       m = 64'd2147483649;
                            3:       m = 64'd4294967295;
                            4:       m = 64'd4294967296;
                            default: m = 64'd0;
                        endcase
                        put_digits(m);
                    end else begin
                        // long run, leading zeros allowed
                        repeat ($urandom_range(11, 20))
                            tok_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    repeat ($urandom_range(0, 2)) tok_chars.push_back(pick_blank());
                    if (kind >= 50)
                        tok_chars.insert($urandom_range(0, tok_chars.size()),
                                         8'($urandom_range(0, 255)));
                end else if (kind < 85) begin
                    repeat ($urandom_range(1, 4))
                        tok_chars.push_back(8'($urandom_range(0, 255)));
                end else if (kind < 95) begin
                    tok_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    if ($urandom_range(0, 1)) begin
                        tok_chars.push_back(pick_blank());
                        put_digits(64'($urandom_range(0, 9)));
                    end
                end
                send_token(bare, t == ntok - 1);
            end
            lists++;
        end

        // Hold the sender off until every owed report is in.
        in_valid <= 1'b0;
        while (token_reports.size() != 0) @(negedge clk);
        @(negedge clk);

        // Fill the store with 0..CAPACITY-1, then one more value reports
        // full; the position wraps to zero on that token. A bare terminator
        // closes the list as skipped.
        tx_steady = 1'b0;
        for (int v = 0; v <= CAPACITY; v++) begin
            tok_chars.delete();
            put_digits(64'(v));
            send_token(1'b0, 1'b0);
        end
        tok_chars.delete();
        send_token(1'b1, 1'b1);
        lists++;

        in_valid <= 1'b0;
        while (token_reports.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d lists, %0d input items, %0d token reports", lists, taken, n_reports);
        $display("reports: ok %0d, not a number %0d, range %0d, dup %0d, full %0d, skipped %0d",
                 by_status[ST_OK], by_status[ST_NOTNUM], by_status[ST_RANGE],
                 by_status[ST_DUP], by_status[ST_FULL], by_status[ST_SKIP]);
        if (errors == 0 && token_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop, several times the slowest legal run (full-list lookups
    // dominate).
    initial begin : watchdog
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
